@@ rtl/core/line_window_clip_top_macros.svh @@
// ----------------------------------------------------------------------------
// line_window_clip_top_macros.svh
// Assertion macros for the line window clipper. Empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef LINE_WINDOW_CLIP_TOP_MACROS_SVH
`define LINE_WINDOW_CLIP_TOP_MACROS_SVH
`ifndef SYNTH
// same-cycle implication, sampled on clk, off during reset
`define LWC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lwc check failed");
// next-cycle implication
`define LWC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lwc check failed");
`else
`define LWC_ASSERT_IMP(lbl, ante, cons)
`define LWC_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

@@ rtl/core/lwc_pkg.sv @@
// ----------------------------------------------------------------------------
// lwc_pkg
// Shared types and constants of the line window clipper.
// ----------------------------------------------------------------------------
package lwc_pkg;

  // control that travels with every pipeline stage
  typedef struct packed {
    logic valid;
    logic rej;      // trivially rejected, no clipping
    logic hi_pend;  // high edge clip still owed for the current point/axis
  } lwc_ctl_t;

  // register map, index = paddr[3:2]
  typedef enum logic [1:0] {
    REG_MIN_X = 2'd0,
    REG_MIN_Y = 2'd1,
    REG_MAX_X = 2'd2,
    REG_MAX_Y = 2'd3
  } lwc_reg_t;

  // reset window edges in whole units
  localparam int WIN_LO_INT = 8;
  localparam int WIN_HI_INT = 504;

  // clip unit selectors
  localparam int PT_A    = 0;
  localparam int PT_B    = 1;
  localparam int AX_X    = 0;
  localparam int AX_Y    = 1;
  localparam int EDGE_LO = 0;
  localparam int EDGE_HI = 1;

endpackage

@@ rtl/core/lwc_clip.sv @@
// ----------------------------------------------------------------------------
// lwc_clip
// One edge clip of one endpoint: slope divide (one quotient bit per stage),
// multiply, truncate, add and saturate.
// ----------------------------------------------------------------------------
`include "line_window_clip_top_macros.svh"

module lwc_clip import lwc_pkg::*; #(
  parameter int W    = 24,
  parameter int F    = 8,
  parameter int PT   = PT_A,
  parameter int AXIS = AX_X,
  parameter int HI   = EDGE_LO
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic signed [W-1:0] lo_edge,
  input  logic signed [W-1:0] hi_edge,
  input  lwc_ctl_t            in_ctl,
  input  logic [4*W-1:0]      in_crd,
  output lwc_ctl_t            out_ctl,
  output logic [4*W-1:0]      out_crd
);

  localparam int NW = W + 1 + F;   // scaled numerator magnitude
  localparam int QB = W - 1;       // quotient bits below saturation
  localparam int CW = 2 * W + F;   // compare width
  localparam int PW = 2 * W + 1;   // product width
  localparam int SU = 2 * PT + AXIS;
  localparam int SV = 2 * PT + (1 - AXIS);
  localparam int TU = 2 * (1 - PT) + AXIS;
  localparam int TV = 2 * (1 - PT) + (1 - AXIS);

  logic signed [W-1:0] cmax, cmin, e;
  assign cmax = {1'b0, {(W-1){1'b1}}};
  assign cmin = {1'b1, {(W-1){1'b0}}};
  assign e    = (HI == EDGE_HI) ? hi_edge : lo_edge;

  // ---------------- prep ----------------
  logic signed [W-1:0] pu, pv, qu, qv;
  logic signed [W:0]   num, den;
  logic [W:0]          nabs, dabs;
  logic                do_c, hip_c;

  always_comb begin
    pu   = in_crd[SU*W +: W];
    pv   = in_crd[SV*W +: W];
    qu   = in_crd[TU*W +: W];
    qv   = in_crd[TV*W +: W];
    num  = (W+1)'(qv) - (W+1)'(pv);
    den  = (W+1)'(qu) - (W+1)'(pu);
    nabs = num[W] ? (W+1)'(-num) : (W+1)'(num);
    dabs = den[W] ? (W+1)'(-den) : (W+1)'(den);
    if (HI == EDGE_HI) begin
      do_c  = in_ctl.hi_pend;
      hip_c = 1'b0;
    end else begin
      do_c  = !in_ctl.rej && (pu < lo_edge);
      hip_c = !in_ctl.rej && (pu > hi_edge);
    end
  end

  lwc_ctl_t          p_ctl;
  logic [4*W-1:0]    p_crd;
  logic              p_do, p_neg, p_nneg, p_zden, p_nz;
  logic [NW-1:0]     p_nmag;
  logic [W:0]        p_dmag;
  logic signed [W:0] p_dist;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_ctl <= '0;
    end else if (en) begin
      p_ctl <= '{valid: in_ctl.valid, rej: in_ctl.rej, hi_pend: hip_c};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_crd  <= in_crd;
      p_do   <= do_c;
      p_neg  <= num[W] ^ den[W];
      p_nneg <= num[W];
      p_zden <= (den == '0);
      p_nz   <= (num != '0);
      p_nmag <= NW'(nabs) << F;
      p_dmag <= dabs;
      p_dist <= (W+1)'(e) - (W+1)'(pu);
    end
  end

  // ---------------- overflow check and divide ----------------
  lwc_ctl_t          dv_ctl  [QB+1];
  logic [4*W-1:0]    dv_crd  [QB+1];
  logic              dv_do   [QB+1];
  logic              dv_neg  [QB+1];
  logic              dv_nneg [QB+1];
  logic              dv_zden [QB+1];
  logic              dv_nz   [QB+1];
  logic              dv_ovf  [QB+1];
  logic [W:0]        dv_dmag [QB+1];
  logic signed [W:0] dv_dist [QB+1];
  logic [NW-1:0]     dv_rem  [QB+1];
  logic [QB-1:0]     dv_q    [QB+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_ctl[0] <= '0;
    end else if (en) begin
      dv_ctl[0] <= p_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_crd[0]  <= p_crd;
      dv_do[0]   <= p_do;
      dv_neg[0]  <= p_neg;
      dv_nneg[0] <= p_nneg;
      dv_zden[0] <= p_zden;
      dv_nz[0]   <= p_nz;
      // quotient of 2^(W-1) or more saturates
      dv_ovf[0]  <= CW'(p_nmag) >= (CW'(p_dmag) << (W - 1));
      dv_dmag[0] <= p_dmag;
      dv_dist[0] <= p_dist;
      dv_rem[0]  <= p_nmag;
      dv_q[0]    <= '0;
    end
  end

  for (genvar k = 0; k < QB; k++) begin : g_div
    localparam int SH = QB - 1 - k;
    logic [CW-1:0] trial;
    logic          take;
    assign trial = CW'(dv_dmag[k]) << SH;
    assign take  = CW'(dv_rem[k]) >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_ctl[k+1] <= '0;
      end else if (en) begin
        dv_ctl[k+1] <= dv_ctl[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_crd[k+1]  <= dv_crd[k];
        dv_do[k+1]   <= dv_do[k];
        dv_neg[k+1]  <= dv_neg[k];
        dv_nneg[k+1] <= dv_nneg[k];
        dv_zden[k+1] <= dv_zden[k];
        dv_nz[k+1]   <= dv_nz[k];
        dv_ovf[k+1]  <= dv_ovf[k];
        dv_dmag[k+1] <= dv_dmag[k];
        dv_dist[k+1] <= dv_dist[k];
        dv_rem[k+1]  <= take ? NW'(CW'(dv_rem[k]) - trial) : dv_rem[k];
        dv_q[k+1]    <= dv_q[k] | (take ? (QB'(1) << SH) : '0);
      end
    end
  end

  // ---------------- slope ----------------
  logic signed [W-1:0] qx, s_c;
  always_comb begin
    qx = {1'b0, dv_q[QB]};
    if (dv_zden[QB]) begin
      s_c = dv_nz[QB] ? (dv_nneg[QB] ? cmin : cmax) : '0;
    end else if (dv_ovf[QB]) begin
      s_c = dv_neg[QB] ? cmin : cmax;
    end else begin
      s_c = dv_neg[QB] ? -qx : qx;
    end
  end

  lwc_ctl_t            s_ctl;
  logic [4*W-1:0]      s_crd;
  logic                s_do;
  logic signed [W-1:0] s_slope;
  logic signed [W:0]   s_dist;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_ctl <= '0;
    end else if (en) begin
      s_ctl <= dv_ctl[QB];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_crd   <= dv_crd[QB];
      s_do    <= dv_do[QB];
      s_slope <= s_c;
      s_dist  <= dv_dist[QB];
    end
  end

  // ---------------- multiply ----------------
  lwc_ctl_t             m_ctl;
  logic [4*W-1:0]       m_crd;
  logic                 m_do;
  logic signed [PW-1:0] m_prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_ctl <= '0;
    end else if (en) begin
      m_ctl <= s_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_crd  <= s_crd;
      m_do   <= s_do;
      m_prod <= PW'(s_slope) * PW'(s_dist);
    end
  end

  // ---------------- truncate toward zero ----------------
  logic signed [PW-1:0] biased;
  assign biased = m_prod + (m_prod[PW-1] ? PW'((1 << F) - 1) : PW'(0));

  lwc_ctl_t             t_ctl;
  logic [4*W-1:0]       t_crd;
  logic                 t_do;
  logic signed [PW-1:0] t_val;

  always_ff @(posedge clk) begin
    if (rst) begin
      t_ctl <= '0;
    end else if (en) begin
      t_ctl <= m_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t_crd <= m_crd;
      t_do  <= m_do;
      t_val <= biased >>> F;
    end
  end

  // ---------------- add, saturate, write back ----------------
  logic signed [W-1:0] t_pv, sat_v;
  logic signed [PW:0]  sum;
  logic [4*W-1:0]      crd_next;

  always_comb begin
    t_pv = t_crd[SV*W +: W];
    sum  = (PW+1)'(t_pv) + (PW+1)'(t_val);
    if (sum > (PW+1)'(cmax)) begin
      sat_v = cmax;
    end else if (sum < (PW+1)'(cmin)) begin
      sat_v = cmin;
    end else begin
      sat_v = sum[W-1:0];
    end
    crd_next = t_crd;
    if (t_do) begin
      crd_next[SV*W +: W] = sat_v;
      crd_next[SU*W +: W] = e;
    end
  end

  logic out_do;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ctl <= '0;
    end else if (en) begin
      out_ctl <= t_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_crd <= crd_next;
      out_do  <= t_do;
    end
  end

  // restoring divide leaves a remainder below the divisor
  `LWC_ASSERT_IMP(a_rem_bound, dv_ctl[QB].valid && !dv_zden[QB] && !dv_ovf[QB],
                  dv_rem[QB] < NW'(dv_dmag[QB]))
  // a rejected segment is never clipped
  `LWC_ASSERT_IMP(a_rej_no_clip, p_ctl.valid && p_ctl.rej, !p_do)
  // a clipped endpoint lands on its edge
  `LWC_ASSERT_IMP(a_edge_hit, out_ctl.valid && out_do,
                  $signed(out_crd[SU*W +: W]) == e)

endmodule

@@ rtl/core/line_window_clip_top.sv @@
// ----------------------------------------------------------------------------
// line_window_clip_top
// Outcode line clipper: one 2D segment in, one clipped segment out.
// ----------------------------------------------------------------------------
// Usage:
//  - Window edges sit in four APB registers (0x0 min_x, 0x4 min_y, 0x8 max_x,
//    0xC max_y), signed fixed point with FRAC_BITS fraction bits. Write them
//    only while no item is in flight. pready is tied high.
//  - Input channel in_valid/in_ready carries start_x/start_y/end_x/end_y;
//    output channel out_valid/out_ready carries the clipped endpoints and
//    the rejected flag. An item moves when valid and ready are both high.
//  - Throughput: one item per cycle, back to back, unless the output stalls.
//  - Pipeline: one entry stage classifies the segment, then eight clip
//    units run in a fixed order (start x, end x, start y, end y; low edge
//    then high edge each), each COORD_WIDTH+5 stages long, set by its
//    one-bit-per-stage slope divider.
//  - Stall: the whole pipe freezes while a result waits unclaimed;
//    in_ready = !out_valid || out_ready. Nothing is dropped or repeated.
//  - Reset: pipe empties, window returns to 8.0 .. 504.0 on both axes.
// ----------------------------------------------------------------------------
module line_window_clip_top import lwc_pkg::*; #(
  parameter int COORD_WIDTH = 24,
  parameter int FRAC_BITS   = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  // config
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [3:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  // input segment
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_WIDTH-1:0] start_x,
  input  logic signed [COORD_WIDTH-1:0] start_y,
  input  logic signed [COORD_WIDTH-1:0] end_x,
  input  logic signed [COORD_WIDTH-1:0] end_y,
  // result
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [COORD_WIDTH-1:0] clipped_start_x,
  output logic signed [COORD_WIDTH-1:0] clipped_start_y,
  output logic signed [COORD_WIDTH-1:0] clipped_end_x,
  output logic signed [COORD_WIDTH-1:0] clipped_end_y,
  output logic                          rejected
);

  localparam int W      = COORD_WIDTH;
  localparam int NUNITS = 8;
  localparam logic signed [W-1:0] RST_LO = W'(WIN_LO_INT <<< FRAC_BITS);
  localparam logic signed [W-1:0] RST_HI = W'(WIN_HI_INT <<< FRAC_BITS);

  // ---------------- window registers ----------------
  logic signed [W-1:0] win_min_x, win_min_y, win_max_x, win_max_y;
  lwc_reg_t            reg_sel;
  logic                wr_en;

  assign pready  = 1'b1;
  assign reg_sel = lwc_reg_t'(paddr[3:2]);
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      win_min_x <= RST_LO;
      win_min_y <= RST_LO;
      win_max_x <= RST_HI;
      win_max_y <= RST_HI;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_MIN_X: win_min_x <= pwdata[W-1:0];
        REG_MIN_Y: win_min_y <= pwdata[W-1:0];
        REG_MAX_X: win_max_x <= pwdata[W-1:0];
        REG_MAX_Y: win_max_y <= pwdata[W-1:0];
        default:   ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_MIN_X: prdata = 32'(win_min_x);
      REG_MIN_Y: prdata = 32'(win_min_y);
      REG_MAX_X: prdata = 32'(win_max_x);
      REG_MAX_Y: prdata = 32'(win_max_y);
      default:   prdata = '0;
    endcase
  end

  // ---------------- pipeline advance ----------------
  lwc_ctl_t       ch_ctl [NUNITS+1];
  logic [4*W-1:0] ch_crd [NUNITS+1];
  logic           en;

  // the last clip stage is the output register
  assign en       = !ch_ctl[NUNITS].valid || out_ready;
  assign in_ready = en;

  // ---------------- entry: trivial reject ----------------
  // shared outside bit on either axis means wholly outside one edge
  logic rej_c;
  assign rej_c = (start_x < win_min_x && end_x < win_min_x) ||
                 (start_x > win_max_x && end_x > win_max_x) ||
                 (start_y < win_min_y && end_y < win_min_y) ||
                 (start_y > win_max_y && end_y > win_max_y);

  always_ff @(posedge clk) begin
    if (rst) begin
      ch_ctl[0] <= '0;
    end else if (en) begin
      ch_ctl[0] <= '{valid: in_valid, rej: rej_c, hi_pend: 1'b0};
    end
  end

  // slot order: start_x, start_y, end_x, end_y
  always_ff @(posedge clk) begin
    if (en) begin
      ch_crd[0] <= {end_y, end_x, start_y, start_x};
    end
  end

  // ---------------- clip chain ----------------
  // unit u: axis = u/4, point = (u/2)%2, edge = u%2
  for (genvar u = 0; u < NUNITS; u++) begin : g_unit
    localparam int AXIS = u / 4;
    localparam int PT   = (u / 2) % 2;
    localparam int HI   = u % 2;

    lwc_clip #(
      .W    (W),
      .F    (FRAC_BITS),
      .PT   (PT),
      .AXIS (AXIS),
      .HI   (HI)
    ) u_clip (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .lo_edge ((AXIS == AX_Y) ? win_min_y : win_min_x),
      .hi_edge ((AXIS == AX_Y) ? win_max_y : win_max_x),
      .in_ctl  (ch_ctl[u]),
      .in_crd  (ch_crd[u]),
      .out_ctl (ch_ctl[u+1]),
      .out_crd (ch_crd[u+1])
    );
  end

  // ---------------- result ----------------
  assign out_valid       = ch_ctl[NUNITS].valid;
  assign rejected        = ch_ctl[NUNITS].rej;
  assign clipped_start_x = ch_crd[NUNITS][0*W +: W];
  assign clipped_start_y = ch_crd[NUNITS][1*W +: W];
  assign clipped_end_x   = ch_crd[NUNITS][2*W +: W];
  assign clipped_end_y   = ch_crd[NUNITS][3*W +: W];

endmodule

@@ test/line_window_clip_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_window_clip_top_tb
// Self-checking bench for the outcode line clipper. Segments go in on a
// valid/ready channel under random idling; a scoreboard predicts each
// clipped segment from its own copy of the window registers and checks the
// results in order. The window is reprogrammed over APB between phases.
// ----------------------------------------------------------------------------
module line_window_clip_top_tb import lwc_pkg::*; ();

  localparam int CW        = 24;
  localparam int FB        = 8;
  localparam int LATENCY   = 8 * CW + 41;
  localparam int IDLE_LIMIT = 5000;  // cycles without any handshake
  localparam int HOLD_LEN  = 600;    // long receiver hold-off, > pipe depth
  localparam longint CMAX  = (longint'(1) << (CW - 1)) - 1;
  localparam longint CMIN  = -CMAX - 1;

  // outcode bits
  localparam int OC_XLO = 1;
  localparam int OC_XHI = 2;
  localparam int OC_YLO = 4;
  localparam int OC_YHI = 8;

  typedef logic signed [CW-1:0] coord_t;

  typedef struct {
    coord_t sx, sy, ex, ey;
  } segment_t;

  typedef struct {
    coord_t sx, sy, ex, ey;
    logic   rej;
  } clipped_t;

  // --------------------------------------------------------------------------
  // Scoreboard: clip predictor plus the queue of expected clipped segments
  // --------------------------------------------------------------------------
  class clip_scoreboard;
    longint   min_x, min_y, max_x, max_y;
    clipped_t pending_q[$];
    int       errors;
    int       checked;
    int       rejects;

    function new();
      min_x = WIN_LO_INT * (1 << FB);
      min_y = WIN_LO_INT * (1 << FB);
      max_x = WIN_HI_INT * (1 << FB);
      max_y = WIN_HI_INT * (1 << FB);
    endfunction

    task report(string what);
      $display("%0t mismatch: %s", $realtime, what);
      errors++;
    endtask

    function automatic longint clamp(longint v);
      if (v > CMAX) return CMAX;
      if (v < CMIN) return CMIN;
      return v;
    endfunction

    // slope in fixed point, saturating; zero denominator goes to the rail, or to zero if the numerator is zero too
    function automatic longint slope(longint num, longint den);
      if (den == 0) begin
        if (num > 0) return CMAX;
        if (num < 0) return CMIN;
        return 0;
      end
      return clamp((num * (longint'(1) << FB)) / den);
    endfunction

    // clip point (au,av) on axis u against lo/hi, heading toward (bu,bv)
    function automatic void clip_axis(int code, int lobit, int hibit,
                                      longint lo, longint hi,
                                      inout longint au, inout longint av,
                                      input longint bu, input longint bv);
      longint s;
      if (code & lobit) begin
        s  = slope(bv - av, bu - au);
        av = clamp(av + (s * (lo - au)) / (longint'(1) << FB));
        au = lo;
      end
      if (code & hibit) begin
        s  = slope(bv - av, bu - au);
        av = clamp(av - (s * (au - hi)) / (longint'(1) << FB));
        au = hi;
      end
    endfunction

    function automatic int xcode(longint x);
      return (x < min_x ? OC_XLO : 0) | (x > max_x ? OC_XHI : 0);
    endfunction

    function automatic int ycode(longint y);
      return (y < min_y ? OC_YLO : 0) | (y > max_y ? OC_YHI : 0);
    endfunction

    function automatic void set_reg(lwc_reg_t r, longint v);
      case (r)
        REG_MIN_X: min_x = v;
        REG_MIN_Y: min_y = v;
        REG_MAX_X: max_x = v;
        REG_MAX_Y: max_y = v;
      endcase
    endfunction

    // accepted input: predict and queue
    function automatic void note(segment_t s);
      longint   ax, ay, bx, by;
      int       ca, cb;
      clipped_t r;
      ax = s.sx; ay = s.sy; bx = s.ex; by = s.ey;
      ca = xcode(ax) | ycode(ay);
      cb = xcode(bx) | ycode(by);
      r.rej = 1'b0;
      if ((ca | cb) != 0) begin
        if ((ca & cb) != 0) begin
          r.rej = 1'b1;
        end else begin
          clip_axis(ca, OC_XLO, OC_XHI, min_x, max_x, ax, ay, bx, by);
          clip_axis(cb, OC_XLO, OC_XHI, min_x, max_x, bx, by, ax, ay);
          clip_axis(ycode(ay), OC_YLO, OC_YHI, min_y, max_y, ay, ax, by, bx);
          clip_axis(ycode(by), OC_YLO, OC_YHI, min_y, max_y, by, bx, ay, ax);
        end
      end
      r.sx = coord_t'(ax); r.sy = coord_t'(ay);
      r.ex = coord_t'(bx); r.ey = coord_t'(by);
      pending_q.push_back(r);
    endfunction

    task check(clipped_t got);
      clipped_t exp;
      if (pending_q.size() == 0) begin
        report("result with nothing expected");
      end else begin
        exp = pending_q.pop_front();
        checked++;
        if (exp.rej) rejects++;
        if (got.sx !== exp.sx)
          report($sformatf("clipped_start_x %0d, want %0d", got.sx, exp.sx));
        if (got.sy !== exp.sy)
          report($sformatf("clipped_start_y %0d, want %0d", got.sy, exp.sy));
        if (got.ex !== exp.ex)
          report($sformatf("clipped_end_x %0d, want %0d", got.ex, exp.ex));
        if (got.ey !== exp.ey)
          report($sformatf("clipped_end_y %0d, want %0d", got.ey, exp.ey));
        if (got.rej !== exp.rej)
          report($sformatf("rejected %0b, want %0b", got.rej, exp.rej));
      end
    endtask
  endclass

  // --------------------------------------------------------------------------
  // DUT hookup
  // --------------------------------------------------------------------------
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_ready;
  coord_t      start_x = '0, start_y = '0, end_x = '0, end_y = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  coord_t      clipped_start_x, clipped_start_y, clipped_end_x, clipped_end_y;
  logic        rejected;

  line_window_clip_top #(.COORD_WIDTH(CW), .FRAC_BITS(FB)) uut (.*);

  always #2 clk = ~clk;

  clip_scoreboard sb = new();

  // knobs the stimulus flips per phase
  bit hold_req = 1'b0;  // receiver: one long hold-off
  bit calm     = 1'b0;  // no idling on either side
  int sent     = 0;
  int idle_cycles = 0;

  // --------------------------------------------------------------------------
  // Result monitor and watchdog. Sampled at the edge, before any NBA lands.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready)
        sb.check('{clipped_start_x, clipped_start_y, clipped_end_x,
                   clipped_end_y, rejected});
      if ((out_valid && out_ready) || (in_valid && in_ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
          $display("[line_window_clip_top] ERROR");
          $finish;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: random ready pattern, a calm stretch, one long hold-off that
  // lets the pipe fill and back up into in_ready.
  // --------------------------------------------------------------------------
  initial begin
    int r;
    @(negedge rst);
    @(posedge clk);
    forever begin
      r = $urandom_range(0, 99);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_LEN) @(posedge clk);
        hold_req = 1'b0;
      end else if (calm || r < 60) begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else if (r < 95) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end else begin
        out_ready <= 1'b0;
        repeat ($urandom_range(20, 80)) @(posedge clk);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sender side
  // --------------------------------------------------------------------------
  // offer one item, wait for the handshake, then maybe leave a gap
  task send_segment(segment_t s);
    int r, gap;
    in_valid <= 1'b1;
    start_x  <= s.sx;
    start_y  <= s.sy;
    end_x    <= s.ex;
    end_y    <= s.ey;
    do @(posedge clk); while (!in_ready);
    sb.note(s);
    sent++;
    r   = $urandom_range(0, 99);
    gap = calm ? 0 : (r < 55) ? 0 : (r < 92) ? $urandom_range(1, 3)
                                             : $urandom_range(10, 60);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // APB write: setup cycle, then access; lands at the access edge
  task write_reg(lwc_reg_t r, longint v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= 32'(v);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    sb.set_reg(r, v);
  endtask

  // drain everything in flight before touching the window
  task drain;
    in_valid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
  endtask

  task set_window(longint mnx, longint mny, longint mxx, longint mxy);
    drain();
    write_reg(REG_MIN_X, mnx);
    write_reg(REG_MIN_Y, mny);
    write_reg(REG_MAX_X, mxx);
    write_reg(REG_MAX_Y, mxy);
  endtask

  // coordinate mostly near the window on that axis, sometimes on an edge,
  // sometimes anywhere in the 24-bit range
  function automatic coord_t pick_coord(longint mn, longint mx);
    longint lo, hi;
    int     r;
    r  = $urandom_range(0, 99);
    lo = ((mn < mx) ? mn : mx) - 8192;
    hi = ((mn < mx) ? mx : mn) + 8192;
    if (lo < CMIN) lo = CMIN;
    if (hi > CMAX) hi = CMAX;
    if (r < 55) return coord_t'(lo + longint'($urandom_range(0, 32'(hi - lo))));
    if (r < 75) return coord_t'(((r & 1) ? mn : mx) + $urandom_range(0, 2) - 1);
    return coord_t'($urandom());
  endfunction

  task random_segments(int n);
    segment_t s;
    repeat (n) begin
      s.sx = pick_coord(sb.min_x, sb.max_x);
      s.sy = pick_coord(sb.min_y, sb.max_y);
      s.ex = pick_coord(sb.min_x, sb.max_x);
      s.ey = pick_coord(sb.min_y, sb.max_y);
      send_segment(s);
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    segment_t dir_q[$];
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed, reset window 8.0 .. 504.0 (2048 .. 129024)
    dir_q = '{
      '{24'sd4096,   24'sd4096,   24'sd100000, 24'sd90000},   // wholly inside
      '{24'sd0,      24'sd4096,   24'sd1000,   24'sd90000},   // both left: reject
      '{24'sd200000, 24'sd4096,   24'sd300000, 24'sd90000},   // both right: reject
      '{24'sd4096,   -24'sd500,   24'sd90000,  24'sd100},     // both above: reject
      '{24'sd4096,   24'sd200000, 24'sd9000,   24'sd140000},  // both below: reject
      '{-24'sd5000,  24'sd4096,   24'sd60000,  24'sd60000},   // start left of window
      '{24'sd60000,  24'sd60000,  24'sd200000, 24'sd10000},   // end right of window
      '{-24'sd5000,  24'sd60000,  24'sd200000, 24'sd70000},   // start left of window, end right of it
      '{24'sd60000,  -24'sd9000,  24'sd60000,  24'sd300000},  // vertical across y
      '{24'sd0,      24'sd0,      24'sd200000, 24'sd200000},  // two corners
      '{24'sd1000,   24'sd0,      24'sd1000,   24'sd200000},  // left corner stays out
      '{24'sd2047,   24'sd0,      24'sd2049,   24'sd8000000}, // steep, slope saturates
      '{24'sd2048,   24'sd2048,   24'sd129024, 24'sd129024},  // exactly on the edges
      '{-24'sd8388608, -24'sd8388608, 24'sd8388607, 24'sd8388607}, // full range
      '{24'sd8388607, -24'sd8388608, -24'sd8388608, 24'sd8388607},
      '{-24'sd8388608, 24'sd60000, 24'sd8388607, 24'sd60000},  // flat, huge dx
      '{24'sd60000,  24'sd8388607, 24'sd60001,  -24'sd8388608},
      '{24'sd8388607, 24'sd8388607, 24'sd8388607, 24'sd8388607},
      '{-24'sd1,     24'sd60000,  24'sd60000,  -24'sd1}
    };
    foreach (dir_q[i]) send_segment(dir_q[i]);
    random_segments(160);

    // inverted window: points may carry both bits of an axis
    set_window(100000, 90000, 5000, -3000);
    hold_req = 1'b1;
    random_segments(110);

    // extreme window: everything is inside
    set_window(CMIN, CMIN, CMAX, CMAX);
    random_segments(60);

    // extreme inverted: every point off the rails is outside both edges
    set_window(CMAX, CMAX, CMIN, CMIN);
    calm = 1'b1;
    random_segments(90);
    calm = 1'b0;

    // degenerate window, a single point at the origin
    set_window(0, 0, 0, 0);
    random_segments(100);

    // lopsided negative window
    set_window(-700000, -40000, -2000, 1500000);
    random_segments(110);

    drain();
    repeat (LATENCY + 10) @(posedge clk);

    $display("%0d segments sent, %0d results checked (%0d rejected)",
             sent, sb.checked, sb.rejects);
    $display("six window settings incl. inverted, full-range and point windows");
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("[line_window_clip_top] OK");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.errors,
               sb.pending_q.size());
      $display("[line_window_clip_top] ERROR");
    end
    $finish;
  end

endmodule
